// ----- hdl/dwc_pkg.sv -----
// Package for the distinct word counter: payload types, control types, constants.
`timescale 1ns / 1ps
package dwc_pkg;

   localparam int DEF_TABLE_DEPTH  = 64;
   localparam int DEF_MAX_WORD_LEN = 8;
   localparam int COUNT_W          = 7;
   localparam int WORD_W           = 64;
   localparam int LEN_W            = 4;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd64;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] distinct_count;
      logic               table_overflow;
      logic               word_truncated;
      logic               final_result;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_HIT,
      ST_INSERT,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic latch_req;
      logic append;
      logic scan_start;
      logic scan_step;
      logic clear_pending;
      logic insert;
      logic load_rsp;
      logic clear_text;
   } dp_cmd_type;

   typedef struct packed {
      logic is_letter;
      logic pend_empty;
      logic count_zero;
      logic hit;
      logic scan_done;
      logic rsp_busy;
      logic last_char;
   } dp_status_type;

endpackage

// ----- hdl/dwc_datapath.sv -----
// Datapath: character folding, pending word, word table memory, count, flags, result register.
`timescale 1ns / 1ps
module dwc_datapath import dwc_pkg::*; #(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
) (
   input  logic               clock,
   input  logic               reset,
   input  req_payload_type    req_data,
   input  logic               csr_valid,
   input  logic [COUNT_W-1:0] csr_data,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_payload_type    rsp_data
);

   localparam int AW        = $clog2(TABLE_DEPTH);
   localparam int DEPTH_CAP = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;

   logic [WORD_W-1:0]  word_store [TABLE_DEPTH];

   logic [7:0]         char_ff, char_in;
   logic               last_ff, last_in;
   logic [WORD_W-1:0]  pend_word_ff, pend_word_in;
   logic [LEN_W-1:0]   pend_len_ff, pend_len_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               trunc_ff, trunc_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic [COUNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [WORD_W-1:0]  rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic [7:0]         lower;
   logic               is_letter;
   logic               issue;
   logic               do_write;
   logic [AW+COUNT_W-1:0] rd_wide, wr_wide;
   logic [AW-1:0]      rd_addr, wr_addr;

   always_comb begin
      lower     = char_ff;
      if (char_ff >= 8'h41 && char_ff <= 8'h5A) begin
         lower = char_ff + 8'h20;
      end
      is_letter = (lower >= 8'h61 && lower <= 8'h7A);
   end

   assign issue    = cmd.scan_step && (scan_idx_ff < count_ff);
   assign do_write = cmd.insert && (count_ff < limit_ff) && (count_ff < 7'(DEPTH_CAP));
   assign rd_wide  = {{AW{1'b0}}, scan_idx_ff};
   assign wr_wide  = {{AW{1'b0}}, count_ff};
   assign rd_addr  = rd_wide[AW-1:0];
   assign wr_addr  = wr_wide[AW-1:0];

   always_comb begin
      char_in      = char_ff;
      last_in      = last_ff;
      pend_word_in = pend_word_ff;
      pend_len_in  = pend_len_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      trunc_in     = trunc_ff;
      limit_in     = limit_ff;
      scan_idx_in  = scan_idx_ff;
      rd_valid_in  = issue;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         limit_in = csr_data;
      end
      if (cmd.latch_req) begin
         char_in = req_data.char_code;
         last_in = req_data.last_char;
      end
      if (cmd.append) begin
         if (pend_len_ff < 4'(MAX_WORD_LEN)) begin
            pend_word_in[{pend_len_ff[2:0], 3'b000} +: 8] = lower;
            pend_len_in = pend_len_ff + 4'd1;
         end else begin
            trunc_in = 1'b1;
         end
      end
      if (cmd.scan_start) begin
         scan_idx_in = '0;
      end else if (issue) begin
         scan_idx_in = scan_idx_ff + 7'd1;
      end
      if (cmd.insert) begin
         if (do_write) begin
            count_in = count_ff + 7'd1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.insert || cmd.clear_pending) begin
         pend_word_in = '0;
         pend_len_in  = '0;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.distinct_count = count_ff;
         rsp_data_in.table_overflow = ovf_ff;
         rsp_data_in.word_truncated = trunc_ff;
         rsp_data_in.final_result   = last_ff;
      end
      if (cmd.clear_text) begin
         pend_word_in = '0;
         pend_len_in  = '0;
         count_in     = '0;
         ovf_in       = 1'b0;
         trunc_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_word_ff <= '0;
         pend_len_ff  <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         trunc_ff     <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         scan_idx_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_word_ff <= pend_word_in;
         pend_len_ff  <= pend_len_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         trunc_ff     <= trunc_in;
         limit_ff     <= limit_in;
         scan_idx_ff  <= scan_idx_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // word table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         word_store[wr_addr] <= pend_word_ff;
      end
      rd_data_ff <= word_store[rd_addr];
   end

   always_comb begin
      status.is_letter  = is_letter;
      status.pend_empty = (pend_len_ff == '0);
      status.count_zero = (count_ff == '0);
      status.hit        = rd_valid_ff && (rd_data_ff == pend_word_ff);
      // all entries issued and the last read already compared
      status.scan_done  = !rd_valid_ff && (scan_idx_ff >= count_ff);
      status.rsp_busy   = rsp_valid_ff && !rsp_ready;
      status.last_char  = last_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/dwc_controller.sv -----
// Controller state machine: sequences append, table scan, insert and result hand-off.
`timescale 1ns / 1ps
module dwc_controller import dwc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // nothing is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.is_letter) begin
               cmd.append = 1'b1;
               state_in   = ST_FINISH;
            end else if (status.pend_empty) begin
               state_in = ST_FINISH;
            end else if (status.count_zero) begin
               state_in = ST_INSERT;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.hit) begin
               state_in = ST_HIT;
            end else if (status.scan_done) begin
               state_in = ST_INSERT;
            end
         end
         ST_HIT: begin
            cmd.clear_pending = 1'b1;
            state_in          = ST_FINISH;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the result register to free up
            if (!status.rsp_busy) begin
               cmd.load_rsp   = 1'b1;
               cmd.clear_text = status.last_char;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/distinct_word_counter.sv -----
// Top level of the distinct word counter: controller plus datapath.
// Usage:
//   req_*  : one character per transaction (char_code, last_char), valid/ready.
//   rsp_*  : one result per character: distinct count so far, sticky overflow
//            and truncation flags, and final_result echoing last_char.
//   csr_*  : write-only entry_limit register, ready whenever reset is low; write
//            it only while no character is in flight.
// Sequencing: a letter, or a non-letter with no open word, goes from idle through
//   decide to finish, which raises rsp_valid once the result register is free; closing
//   a word scans the N stored entries (one table read per cycle through the single read
//   port, stopping early on a match) and inserts it if no match. One character is
//   handled at a time; the next is accepted when the controller returns to idle.
// The result register lets the next character be accepted while a result
//   waits; if the receiver still stalls, the controller holds its result until
//   the register frees.
// Reset clears the word state, count and flags and sets entry_limit to 64.
//   After a last_char transaction the word state, count and flags clear again.
`timescale 1ns / 1ps
module distinct_word_counter import dwc_pkg::*; #(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_payload_type    req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_payload_type    rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = !reset;

   dwc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dwc_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_WORD_LEN (MAX_WORD_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/sv/distinct_word_counter_tb.sv -----
// Self-checking testbench for distinct_word_counter: character streams checked against a word-table predictor.
`timescale 1ns / 1ps
module distinct_word_counter_tb;
   import dwc_pkg::*;

   localparam int TABLE_DEPTH    = DEF_TABLE_DEPTH;
   localparam int MAX_WORD_LEN   = DEF_MAX_WORD_LEN;
   localparam int STALL_LIMIT    = 4000;
   localparam int SETTING_BUDGET = 60;
   localparam int DRAIN_CYCLES   = 80;
   localparam logic [7:0] LOWER_A  = "a";
   localparam logic [7:0] LOWER_Z  = "z";
   localparam logic [7:0] UPPER_A  = "A";
   localparam logic [7:0] UPPER_Z  = "Z";
   localparam logic [7:0] CASE_GAP = 8'h20;

   typedef struct packed {
      logic [11:0][7:0] letters;
      logic [3:0]       len;
   } spelled_word_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_payload_type    req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_payload_type    rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data;

   // predictor copy of the word table and flags
   logic [WORD_W-1:0] known_words [TABLE_DEPTH];
   logic [WORD_W-1:0] open_word;
   int unsigned       open_len;
   int unsigned       known_count;
   bit                overflow_flag;
   bit                truncation_flag;
   int unsigned       entry_limit;

   rsp_payload_type expected_counts [$];
   int failures      = 0;
   int chars_sent    = 0;
   int idle_cycles   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   distinct_word_counter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= LOWER_A && c <= LOWER_Z) || (c >= UPPER_A && c <= UPPER_Z);
   endfunction

   function automatic void clear_text();
      open_word       = '0;
      open_len        = 0;
      known_count     = 0;
      overflow_flag   = 1'b0;
      truncation_flag = 1'b0;
   endfunction

   function automatic rsp_payload_type count_char(input req_payload_type item);
      logic [7:0]      c;
      int unsigned     cap;
      bit              found;
      rsp_payload_type r;
      c = item.char_code;
      if (c >= UPPER_A && c <= UPPER_Z) c = c + CASE_GAP;
      if (is_letter(c)) begin
         if (open_len < MAX_WORD_LEN) begin
            open_word[8*open_len +: 8] = c;
            open_len++;
         end else begin
            truncation_flag = 1'b1;
         end
      end else if (open_len != 0) begin
         // limits above the table depth saturate
         cap   = (entry_limit > TABLE_DEPTH) ? TABLE_DEPTH : entry_limit;
         found = 1'b0;
         for (int i = 0; i < known_count; i++)
            if (known_words[i] == open_word) found = 1'b1;
         if (!found) begin
            if (known_count < cap) begin
               known_words[known_count] = open_word;
               known_count++;
            end else begin
               overflow_flag = 1'b1;
            end
         end
         open_word = '0;
         open_len  = 0;
      end
      r.distinct_count = COUNT_W'(known_count);
      r.table_overflow = overflow_flag;
      r.word_truncated = truncation_flag;
      r.final_result   = item.last_char;
      // an open word at the last character is dropped with the rest
      if (item.last_char) clear_text();
      return r;
   endfunction

   function automatic logic [7:0] pick_separator();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (is_letter(c));
      return c;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         failures++;
      end
   endfunction

   task automatic send_char(input logic [7:0] code, input logic last);
      req_payload_type item;
      item.char_code = code;
      item.last_char = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_counts.push_back(count_char(item));
      chars_sent++;
   endtask

   task automatic send_chars(input string s, input bit last_on_end);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], last_on_end && i == s.len() - 1);
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
   endtask

   task automatic write_entry_limit(input int unsigned value);
      wait_results_done();
      csr_valid <= 1'b1;
      csr_data  <= COUNT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      entry_limit = value;
   endtask

   // One text: words with random case, some repeated, stray bytes, closed by last_char
   task automatic send_text(input int n_words, input int reuse_pct);
      spelled_word_type used [$];
      spelled_word_type w;
      logic [7:0]  c;
      bit          open_end;
      bit          last_word;
      open_end = ($urandom_range(99) < 30);
      for (int k = 0; k < n_words; k++) begin
         last_word = (k == n_words - 1);
         if ($urandom_range(99) < 10)
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)), 1'b0);
         if (used.size() != 0 && $urandom_range(99) < reuse_pct) begin
            w = used[$urandom_range(used.size() - 1)];
         end else begin
            w.len = ($urandom_range(99) < 12) ? 4'($urandom_range(9, 12))
                                              : 4'($urandom_range(1, 5));
            for (int i = 0; i < 12; i++) w.letters[i] = 8'($urandom_range(LOWER_A, LOWER_Z));
            used.push_back(w);
         end
         for (int i = 0; i < w.len; i++) begin
            c = w.letters[i];
            if ($urandom_range(1) == 1) c = c - CASE_GAP;
            send_char(c, open_end && last_word && i == w.len - 1);
         end
         if (!(open_end && last_word)) send_char(pick_separator(), last_word);
      end
   endtask

   task automatic test_case_folding();
      send_chars("Az", 1'b0);
      send_char(8'h00, 1'b0);
      send_chars("Za", 1'b0);
      send_char(8'h80, 1'b0);
      send_chars("aZ", 1'b0);
      send_char(8'hFF, 1'b0);
      // separators next to the letter ranges, no open word
      send_chars("@[`{", 1'b0);
   endtask

   task automatic test_truncation();
      send_chars("abcdefghiJ?", 1'b1);
   endtask

   task automatic test_unterminated_word();
      send_chars("Qr", 1'b1);
   endtask

   task automatic test_limit_zero();
      write_entry_limit(0);
      send_chars("b ", 1'b1);
   endtask

   task automatic test_limit_one();
      write_entry_limit(1);
      send_chars("x y.", 1'b1);
   endtask

   task automatic test_random_traffic();
      int unsigned limits [8];
      int          budget_start;
      limits = '{127, 3, 64, 0, 1, 0, 96, 0};
      limits[5] = $urandom_range(2, 30);
      limits[7] = $urandom_range(0, 127);
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 79;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 79;
            end
            default: begin
               send_idle_pct = 11;
               stall_pct     = 11;
            end
         endcase
         for (int s = 0; s < 2; s++) begin
            write_entry_limit(limits[2*p+s]);
            budget_start = chars_sent;
            // enough new words to fill the whole table
            if (entry_limit >= TABLE_DEPTH) send_text(80, 4);
            while (chars_sent - budget_start < SETTING_BUDGET)
               send_text($urandom_range(1, 20), 40);
         end
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_counts.size() == 0) begin
            $display("%0t: result with none expected: count %0d ovf %0d trunc %0d final %0d",
                     $time, rsp_data.distinct_count, rsp_data.table_overflow,
                     rsp_data.word_truncated, rsp_data.final_result);
            failures++;
         end else begin
            want = expected_counts.pop_front();
            check_field("distinct_count", want.distinct_count, rsp_data.distinct_count);
            check_field("table_overflow", want.table_overflow, rsp_data.table_overflow);
            check_field("word_truncated", want.word_truncated, rsp_data.word_truncated);
            check_field("final_result", want.final_result, rsp_data.final_result);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      entry_limit = LIMIT_RESET;
      clear_text();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_case_folding();
      test_truncation();
      test_unterminated_word();
      test_limit_zero();
      test_limit_one();
      test_random_traffic();

      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
